>>> rtl/cita_pkg.sv
// ----------------------------------------------------------------------------
// cita_pkg
// shared codes and widths for the camera/imu timestamp aligner
// ----------------------------------------------------------------------------
package cita_pkg;
   localparam int STAMP_BITS = 52;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 26;

   typedef logic [1:0] op_type;
   localparam op_type OP_ADD_IMU   = 2'd0;
   localparam op_type OP_ADD_FRAME = 2'd1;
   localparam op_type OP_REQUEST   = 2'd2;
   localparam op_type OP_UNUSED    = 2'd3;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FRAME  = 2'd0;
   localparam kind_type KIND_IMU    = 2'd1;
   localparam kind_type KIND_STATUS = 2'd2;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_IGNORED     = 3'd1;
   localparam status_type ST_DROPPED     = 3'd2;
   localparam status_type ST_NOT_RUNNING = 3'd3;
   localparam status_type ST_EMPTY       = 3'd4;
   localparam status_type ST_GAP_CLEARED = 3'd5;
   localparam status_type ST_WAITING     = 3'd6;
   localparam status_type ST_MISS_CLEARED = 3'd7;

   typedef logic [1:0] phase_type;
   localparam phase_type PH_IDLE    = 2'd0;
   localparam phase_type PH_STARTED = 2'd1;
   localparam phase_type PH_RUNNING = 2'd2;

   typedef logic [CSR_ADDR_BITS-1:0] csr_idx_type;
   localparam csr_idx_type CSR_IMAGE_DELAY = 3'd0;
   localparam csr_idx_type CSR_GAP_TOL     = 3'd1;
   localparam csr_idx_type CSR_IMAGE_WAIT  = 3'd2;
   localparam csr_idx_type CSR_IMU_WAIT    = 3'd3;
   localparam csr_idx_type CSR_MISS_LIMIT  = 3'd4;
endpackage

>>> rtl/camera_imu_timestamp_aligner.sv
// ----------------------------------------------------------------------------
// camera_imu_timestamp_aligner
// queues camera frame and imu sample tags and hands out aligned groups
// ----------------------------------------------------------------------------
// req_ carries one command per beat: tuser is the op (add imu, add frame,
// request), tdata holds stamp and tag. rsp_ carries result beats: tuser is the
// kind, tdata holds stamp, tag and status, tlast marks the final beat of a
// command. csr_ writes the five setup registers, only while idle: a rule
// for the user, which the block itself does not enforce. An add passes
// through the execute and send states to its status beat; a new command is
// taken only once the previous one has finished its work. A request reads
// queue head and tail from the two queue memories (one read port each) and
// passes the read-back, compare, decide and frame states to its first beat;
// each further imu beat passes the next and read states for the imu head read.
// The result register holds a beat while rsp_tready is low; the sequencer
// waits with it and holds its state. Reset empties both queues, sets the
// phase to not started and loads register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module camera_imu_timestamp_aligner #(
   parameter int FRAME_DEPTH = 16,
   parameter int IMU_DEPTH = 32,
   parameter int TAG_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // stamp_us, msg_tag
   input  logic [((cita_pkg::STAMP_BITS+TAG_BITS+7)/8)*8-1:0] req_tdata,
   // op
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_stamp_us, out_tag, status
   output logic [((cita_pkg::STAMP_BITS+TAG_BITS+3+7)/8)*8-1:0] rsp_tdata,
   // kind
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [cita_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [cita_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import cita_pkg::*;

   localparam int SB = STAMP_BITS;
   localparam int EW = SB + TAG_BITS;
   localparam int OW = ((SB + TAG_BITS + 3 + 7) / 8) * 8;
   localparam int FAW = $clog2(FRAME_DEPTH);
   localparam int FCW = $clog2(FRAME_DEPTH + 1);
   localparam int IAW = $clog2(IMU_DEPTH);
   localparam int ICW = $clog2(IMU_DEPTH + 1);
   localparam int XW = SB + 3;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SEND, S_RD_BACK, S_CMP, S_DECIDE, S_FRM, S_NXT, S_NRD
   } state_type;

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [SB-1:0] stamp_ff, stamp_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   phase_type phase_ff, phase_in;
   logic [SB-1:0] start_ff, start_in;
   logic [4:0] miss_ff, miss_in;
   logic [FAW-1:0] fhead_ff, fhead_in;
   logic [FCW-1:0] fcount_ff, fcount_in;
   logic [IAW-1:0] ihead_ff, ihead_in;
   logic [ICW-1:0] icount_ff, icount_in;
   logic signed [20:0] delay_ff, delay_in;
   logic [25:0] gap_ff, gap_in;
   logic [4:0] iwc_ff, iwc_in;
   logic [5:0] mwc_ff, mwc_in;
   logic [4:0] mlim_ff, mlim_in;
   logic [SB-1:0] ffront_ff, ffront_in;
   logic [TAG_BITS-1:0] ftag_ff, ftag_in;
   logic [SB-1:0] cand_ff, cand_in;
   logic [TAG_BITS-1:0] ctag_ff, ctag_in;
   logic signed [XW-1:0] limit_ff, limit_in;
   status_type res_ff, res_in;
   logic rlast_ff, rlast_in;
   logic rsp_valid_ff, rsp_valid_in;
   kind_type rsp_kind_ff, rsp_kind_in;
   logic [SB-1:0] rsp_stamp_ff, rsp_stamp_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   status_type rsp_status_ff, rsp_status_in;
   logic rsp_last_ff, rsp_last_in;

   logic f_we, i_we;
   logic [FAW-1:0] f_waddr, f_raddr, ftail, fback, fhead_nx;
   logic [IAW-1:0] i_waddr, i_raddr, itail, iback, ihead_nx;
   logic [EW-1:0] f_rd, i_rd;
   logic [FAW:0] fsum, fsum1;
   logic [IAW:0] isum, isum1;
   logic out_free;
   logic signed [XW-1:0] d_s, gap_s, st_s, start_s, fb_s, ib_s, ff_s, if_s, ir_s, cand_s;

   cita_mem #(.DEPTH(FRAME_DEPTH), .WIDTH(EW), .AW(FAW)) u_frame_mem (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr),
      .wr_data({tag_ff, stamp_ff}), .rd_addr(f_raddr), .rd_data(f_rd)
   );

   cita_mem #(.DEPTH(IMU_DEPTH), .WIDTH(EW), .AW(IAW)) u_imu_mem (
      .clock(clock), .wr_en(i_we), .wr_addr(i_waddr),
      .wr_data({tag_ff, stamp_ff}), .rd_addr(i_raddr), .rd_data(i_rd)
   );

   always_comb begin
      fsum = {1'b0, fhead_ff} + (FAW+1)'(fcount_ff);
      fsum1 = fsum - (FAW+1)'(1);
      ftail = (fsum >= (FAW+1)'(FRAME_DEPTH)) ? FAW'(fsum - (FAW+1)'(FRAME_DEPTH)) : FAW'(fsum);
      fback = (fsum1 >= (FAW+1)'(FRAME_DEPTH)) ?
              FAW'(fsum1 - (FAW+1)'(FRAME_DEPTH)) : FAW'(fsum1);
      fhead_nx = (fhead_ff == FAW'(FRAME_DEPTH - 1)) ? '0 : fhead_ff + FAW'(1);
      isum = {1'b0, ihead_ff} + (IAW+1)'(icount_ff);
      isum1 = isum - (IAW+1)'(1);
      itail = (isum >= (IAW+1)'(IMU_DEPTH)) ? IAW'(isum - (IAW+1)'(IMU_DEPTH)) : IAW'(isum);
      iback = (isum1 >= (IAW+1)'(IMU_DEPTH)) ? IAW'(isum1 - (IAW+1)'(IMU_DEPTH)) : IAW'(isum1);
      ihead_nx = (ihead_ff == IAW'(IMU_DEPTH - 1)) ? '0 : ihead_ff + IAW'(1);
      f_raddr = (state_ff == S_RD_BACK) ? fback : fhead_ff;
      i_raddr = (state_ff == S_RD_BACK) ? iback : ihead_ff;
      f_waddr = ftail;
      i_waddr = itail;

      d_s = $signed({{(XW-21){delay_ff[20]}}, delay_ff});
      gap_s = $signed({{(XW-26){1'b0}}, gap_ff});
      st_s = $signed({3'b000, stamp_ff});
      start_s = $signed({3'b000, start_ff});
      fb_s = $signed({3'b000, f_rd[SB-1:0]});
      ib_s = $signed({3'b000, i_rd[SB-1:0]});
      ir_s = ib_s;
      ff_s = $signed({3'b000, ffront_ff});
      if_s = $signed({3'b000, cand_ff});
      cand_s = if_s;
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      stamp_in = stamp_ff;
      tag_in = tag_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      miss_in = miss_ff;
      fhead_in = fhead_ff;
      fcount_in = fcount_ff;
      ihead_in = ihead_ff;
      icount_in = icount_ff;
      delay_in = delay_ff;
      gap_in = gap_ff;
      iwc_in = iwc_ff;
      mwc_in = mwc_ff;
      mlim_in = mlim_ff;
      ffront_in = ffront_ff;
      ftag_in = ftag_ff;
      cand_in = cand_ff;
      ctag_in = ctag_ff;
      limit_in = limit_ff;
      res_in = res_ff;
      rlast_in = rlast_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_stamp_in = rsp_stamp_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = rsp_last_ff;
      f_we = 1'b0;
      i_we = 1'b0;
      req_tready = (state_ff == S_IDLE);

      if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_DELAY: delay_in = $signed(csr_wdata[20:0]);
            CSR_GAP_TOL:     gap_in = csr_wdata;
            CSR_IMAGE_WAIT:  iwc_in = csr_wdata[4:0];
            CSR_IMU_WAIT:    mwc_in = csr_wdata[5:0];
            CSR_MISS_LIMIT:  mlim_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               stamp_in = req_tdata[SB-1:0];
               tag_in = req_tdata[EW-1:SB];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_SEND;
            res_in = ST_OK;
            unique case (op_ff)
               OP_ADD_IMU: begin
                  if ((delay_ff >= 0) || phase_ff == PH_RUNNING ||
                      (phase_ff == PH_STARTED && st_s + d_s > start_s)) begin
                     if (icount_ff == ICW'(IMU_DEPTH)) begin
                        res_in = ST_DROPPED;
                     end else begin
                        i_we = 1'b1;
                        icount_in = icount_ff + ICW'(1);
                        if (delay_ff >= 0) begin
                           if (phase_ff == PH_IDLE) begin
                              start_in = stamp_ff;
                              phase_in = PH_STARTED;
                           end
                        end else if (phase_ff == PH_STARTED) begin
                           phase_in = PH_RUNNING;
                        end
                     end
                  end else begin
                     res_in = ST_IGNORED;
                  end
               end
               OP_ADD_FRAME: begin
                  if (delay_ff < 0 && phase_ff == PH_IDLE) begin
                     start_in = stamp_ff;
                     phase_in = PH_STARTED;
                  end else if (delay_ff < 0 || phase_ff == PH_RUNNING ||
                               (phase_ff == PH_STARTED && st_s - d_s > start_s)) begin
                     if (fcount_ff == FCW'(FRAME_DEPTH)) begin
                        res_in = ST_DROPPED;
                     end else begin
                        f_we = 1'b1;
                        fcount_in = fcount_ff + FCW'(1);
                        if (delay_ff >= 0 && phase_ff == PH_STARTED) begin
                           phase_in = PH_RUNNING;
                        end
                     end
                  end else begin
                     res_in = ST_IGNORED;
                  end
               end
               OP_REQUEST: begin
                  if (phase_ff != PH_RUNNING) begin
                     res_in = ST_NOT_RUNNING;
                  end else if (fcount_ff == '0 || icount_ff == '0) begin
                     res_in = ST_EMPTY;
                  end else begin
                     state_in = S_RD_BACK;
                  end
               end
               OP_UNUSED: res_in = ST_IGNORED;
               default: res_in = ST_IGNORED;
            endcase
         end
         S_RD_BACK: begin
            ffront_in = f_rd[SB-1:0];
            ftag_in = f_rd[EW-1:SB];
            cand_in = i_rd[SB-1:0];
            ctag_in = i_rd[EW-1:SB];
            state_in = S_CMP;
         end
         S_CMP: begin
            limit_in = ff_s - d_s;
            state_in = S_DECIDE;
            if ((fb_s - d_s + gap_s < if_s) || (ff_s - d_s > ib_s + gap_s)) begin
               res_in = ST_GAP_CLEARED;
               fhead_in = '0;
               fcount_in = '0;
               ihead_in = '0;
               icount_in = '0;
               state_in = S_SEND;
            end else if (32'(fcount_ff) < 32'(iwc_ff) && 32'(icount_ff) < 32'(mwc_ff) &&
                         (ff_s - d_s > ib_s)) begin
               res_in = ST_WAITING;
               state_in = S_SEND;
            end
         end
         S_DECIDE: begin
            if (!(cand_s < limit_ff) && miss_ff > mlim_ff) begin
               miss_in = '0;
               fhead_in = '0;
               fcount_in = '0;
               ihead_in = '0;
               icount_in = '0;
               res_in = ST_MISS_CLEARED;
               state_in = S_SEND;
            end else begin
               fhead_in = fhead_nx;
               fcount_in = fcount_ff - FCW'(1);
               state_in = S_FRM;
               if (cand_s < limit_ff) begin
                  ihead_in = ihead_nx;
                  icount_in = icount_ff - ICW'(1);
                  miss_in = '0;
                  rlast_in = 1'b0;
               end else begin
                  if (miss_ff != 5'd31) begin
                     miss_in = miss_ff + 5'd1;
                  end
                  rlast_in = 1'b1;
               end
            end
         end
         S_FRM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_FRAME;
               rsp_stamp_in = ffront_ff;
               rsp_tag_in = ftag_ff;
               rsp_status_in = ST_OK;
               rsp_last_in = rlast_ff;
               state_in = rlast_ff ? S_IDLE : S_NXT;
            end
         end
         S_NXT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_IMU;
               rsp_stamp_in = cand_ff;
               rsp_tag_in = ctag_ff;
               rsp_status_in = ST_OK;
               if (icount_ff != '0 && ir_s < limit_ff) begin
                  rsp_last_in = 1'b0;
                  cand_in = i_rd[SB-1:0];
                  ctag_in = i_rd[EW-1:SB];
                  ihead_in = ihead_nx;
                  icount_in = icount_ff - ICW'(1);
                  state_in = S_NRD;
               end else begin
                  // stopped on a later sample: one miss after the pops
                  if (icount_ff != '0) begin
                     miss_in = 5'd1;
                  end
                  rsp_last_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_NRD: state_in = S_NXT;
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_STATUS;
               rsp_stamp_in = '0;
               rsp_tag_in = '0;
               rsp_status_in = res_ff;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_IDLE;
         start_ff <= '0;
         miss_ff <= '0;
         fhead_ff <= '0;
         fcount_ff <= '0;
         ihead_ff <= '0;
         icount_ff <= '0;
         delay_ff <= '0;
         gap_ff <= 26'd3000000;
         iwc_ff <= 5'd10;
         mwc_ff <= 6'd15;
         mlim_ff <= 5'd10;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         miss_ff <= miss_in;
         fhead_ff <= fhead_in;
         fcount_ff <= fcount_in;
         ihead_ff <= ihead_in;
         icount_ff <= icount_in;
         delay_ff <= delay_in;
         gap_ff <= gap_in;
         iwc_ff <= iwc_in;
         mwc_ff <= mwc_in;
         mlim_ff <= mlim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      stamp_ff <= stamp_in;
      tag_ff <= tag_in;
      ffront_ff <= ffront_in;
      ftag_ff <= ftag_in;
      cand_ff <= cand_in;
      ctag_ff <= ctag_in;
      limit_ff <= limit_in;
      res_ff <= res_in;
      rlast_ff <= rlast_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_stamp_ff <= rsp_stamp_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = OW'({rsp_status_ff, rsp_tag_ff, rsp_stamp_ff});
endmodule

>>> rtl/cita_mem.sv
// ----------------------------------------------------------------------------
// cita_mem
// queue storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module cita_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 68,
   parameter int AW = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/cita_checker.sv
// ----------------------------------------------------------------------------
// cita_checker
// port-level checks on the result channel of the aligner
// ----------------------------------------------------------------------------
module cita_checker #(
   parameter int TAG_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((cita_pkg::STAMP_BITS+TAG_BITS+3+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic rsp_tlast
);
   import cita_pkg::*;

   localparam int SB = STAMP_BITS;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tlast && rsp_tdata[SB-1:0] == '0)
      else $error("status beat not final or carries a stamp");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_FRAME || rsp_tuser == KIND_IMU) |->
      rsp_tdata[SB+TAG_BITS+2:SB+TAG_BITS] == ST_OK)
      else $error("data beat with non-ok status");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");
endmodule

bind camera_imu_timestamp_aligner cita_checker #(.TAG_BITS(TAG_BITS)) u_cita_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
